/* src/dqmm_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Deque package
// Request and response types, codes and defaults shared by the deque design.
// ----------------------------------------------------------------------------
package dqmm_pkg;

  // Default number of ring entries.
  localparam int unsigned DefaultDepth = 64;

  typedef enum logic [2:0] {
    REQ_PUSH_FRONT = 3'd0,
    REQ_PUSH_BACK  = 3'd1,
    REQ_POP_FRONT  = 3'd2,
    REQ_POP_BACK   = 3'd3,
    REQ_QUERY      = 3'd4
  } req_type_e;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_FULL  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_POP,
    ST_SCAN
  } state_e;

  typedef struct packed {
    req_type_e          req_type;
    logic signed [31:0] push_value;
  } dqmm_req_t;

  typedef struct packed {
    status_e            status;
    logic signed [31:0] popped_value;
    logic signed [31:0] largest;
    logic signed [31:0] smallest;
  } dqmm_rsp_t;

endpackage

/* src/deque_with_min_max_scan_top.sv */
// Responses: a push, an unused code, or a pop or query on an empty queue
// answers in the cycle after the request. A pop reads the entry memory and
// answers from ST_POP; a query reads the entry memory port once per stored
// entry, first on acceptance, then in ST_SCAN. One request is in flight at
// a time: a new request is taken only once the response has been taken.
// Reset (asynchronous, active low) empties the queue; memory is not cleared.
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Double-ended queue with min/max scan
// Ring buffer of signed 32-bit entries with push and pop at both ends and a
// sequential scan that reports the largest and smallest stored value.
// ----------------------------------------------------------------------------
module deque_with_min_max_scan_top
  import dqmm_pkg::*;
#(
  parameter int unsigned DEPTH = DefaultDepth
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      req_valid_i,
  output logic      req_ready_o,
  input  dqmm_req_t req_i,
  output logic      rsp_valid_o,
  input  logic      rsp_ready_i,
  output dqmm_rsp_t rsp_o
);

  // Index width addresses every entry; the count width also holds DEPTH.
  localparam int unsigned IdxW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(DEPTH - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

  function automatic logic [IdxW-1:0] ring_next(input logic [IdxW-1:0] i);
    ring_next = (i == LastIdx) ? '0 : i + 1'b1;
  endfunction

  function automatic logic [IdxW-1:0] ring_prev(input logic [IdxW-1:0] i);
    ring_prev = (i == '0) ? LastIdx : i - 1'b1;
  endfunction

  // Sequencer and ring pointers. head_q points at the front entry, tail_q at
  // the free slot just past the back entry.
  state_e            state_q, state_d;
  logic [IdxW-1:0]   head_q, head_d;
  logic [IdxW-1:0]   tail_q, tail_d;
  logic [CntW-1:0]   count_q, count_d;

  // Scan bookkeeping: next address to read and the number of reads still to
  // issue. The first entry seen loads both running extremes.
  logic [IdxW-1:0]   scan_idx_q, scan_idx_d;
  logic [CntW-1:0]   remain_q, remain_d;
  logic              first_q, first_d;
  logic signed [31:0] hi_q, hi_d;
  logic signed [31:0] lo_q, lo_d;

  // Response register. It decouples the sequencer from the response side.
  logic              rsp_valid_q, rsp_valid_d;
  dqmm_rsp_t         rsp_q, rsp_d;

  // Entry memory: one write port, one registered read port.
  logic signed [31:0] mem_q [DEPTH];
  logic               wr_en;
  logic [IdxW-1:0]    wr_addr;
  logic signed [31:0] wr_data;
  logic [IdxW-1:0]    rd_addr;
  logic signed [31:0] rd_data_q;

  logic              req_fire;
  logic              is_full;
  logic              is_empty;
  logic signed [31:0] cand_hi;
  logic signed [31:0] cand_lo;

  assign req_ready_o = (state_q == ST_IDLE) && !rsp_valid_q;
  assign req_fire    = req_valid_i && req_ready_o;
  assign is_full     = (count_q == FullCnt);
  assign is_empty    = (count_q == '0);

  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

  // The shared compare unit: the entry just read against the running
  // extremes, or taken as both when it is the first one of the scan.
  assign cand_hi = (first_q || (rd_data_q > hi_q)) ? rd_data_q : hi_q;
  assign cand_lo = (first_q || (rd_data_q < lo_q)) ? rd_data_q : lo_q;

  // Next-state logic of the sequencer.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (req_fire && !is_empty) begin
          if ((req_i.req_type == REQ_POP_FRONT) || (req_i.req_type == REQ_POP_BACK)) begin
            state_d = ST_POP;
          end else if (req_i.req_type == REQ_QUERY) begin
            state_d = ST_SCAN;
          end
        end
      end
      ST_POP: begin
        state_d = ST_IDLE;
      end
      ST_SCAN: begin
        if (remain_q == '0) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Datapath and memory control for each state.
  always_comb begin
    head_d      = head_q;
    tail_d      = tail_q;
    count_d     = count_q;
    scan_idx_d  = scan_idx_q;
    remain_d    = remain_q;
    first_d     = first_q;
    hi_d        = hi_q;
    lo_d        = lo_q;
    rsp_valid_d = rsp_valid_q && !rsp_ready_i;
    rsp_d       = rsp_q;
    wr_en       = 1'b0;
    wr_addr     = tail_q;
    wr_data     = req_i.push_value;
    rd_addr     = scan_idx_q;

    unique case (state_q)
      ST_IDLE: begin
        if (req_fire) begin
          // Value fields are zero unless a pop or a query fills them later.
          rsp_d = '{status: STATUS_OK, popped_value: '0, largest: '0, smallest: '0};
          unique case (req_i.req_type)
            REQ_PUSH_FRONT: begin
              rsp_valid_d = 1'b1;
              if (is_full) begin
                rsp_d.status = STATUS_FULL;
              end else begin
                head_d  = ring_prev(head_q);
                wr_en   = 1'b1;
                wr_addr = ring_prev(head_q);
                count_d = count_q + 1'b1;
              end
            end
            REQ_PUSH_BACK: begin
              rsp_valid_d = 1'b1;
              if (is_full) begin
                rsp_d.status = STATUS_FULL;
              end else begin
                tail_d  = ring_next(tail_q);
                wr_en   = 1'b1;
                wr_addr = tail_q;
                count_d = count_q + 1'b1;
              end
            end
            REQ_POP_FRONT: begin
              if (is_empty) begin
                rsp_valid_d  = 1'b1;
                rsp_d.status = STATUS_EMPTY;
              end else begin
                rd_addr = head_q;
                head_d  = ring_next(head_q);
                count_d = count_q - 1'b1;
              end
            end
            REQ_POP_BACK: begin
              if (is_empty) begin
                rsp_valid_d  = 1'b1;
                rsp_d.status = STATUS_EMPTY;
              end else begin
                rd_addr = ring_prev(tail_q);
                tail_d  = ring_prev(tail_q);
                count_d = count_q - 1'b1;
              end
            end
            REQ_QUERY: begin
              if (is_empty) begin
                rsp_valid_d  = 1'b1;
                rsp_d.status = STATUS_EMPTY;
              end else begin
                rd_addr    = head_q;
                scan_idx_d = ring_next(head_q);
                remain_d   = count_q - 1'b1;
                first_d    = 1'b1;
              end
            end
            default: begin
              // Unused codes answer ok and leave the queue alone.
              rsp_valid_d = 1'b1;
            end
          endcase
        end
      end
      ST_POP: begin
        rsp_valid_d = 1'b1;
        rsp_d = '{status: STATUS_OK, popped_value: rd_data_q, largest: '0, smallest: '0};
      end
      ST_SCAN: begin
        hi_d    = cand_hi;
        lo_d    = cand_lo;
        first_d = 1'b0;
        if (remain_q != '0) begin
          rd_addr    = scan_idx_q;
          scan_idx_d = ring_next(scan_idx_q);
          remain_d   = remain_q - 1'b1;
        end else begin
          rsp_valid_d = 1'b1;
          rsp_d = '{status: STATUS_OK, popped_value: '0, largest: cand_hi, smallest: cand_lo};
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      head_q      <= '0;
      tail_q      <= '0;
      count_q     <= '0;
      scan_idx_q  <= '0;
      remain_q    <= '0;
      first_q     <= 1'b0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      count_q     <= count_d;
      scan_idx_q  <= scan_idx_d;
      remain_q    <= remain_d;
      first_q     <= first_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hi_q  <= hi_d;
    lo_q  <= lo_d;
    rsp_q <= rsp_d;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    rd_data_q <= mem_q[rd_addr];
  end

  // Where the tail must sit given the head and the fill level.
  logic [CntW:0]     tail_sum;
  logic [IdxW-1:0]   tail_expect;
  assign tail_sum    = {{(CntW + 1 - IdxW){1'b0}}, head_q} + {1'b0, count_q};
  assign tail_expect = (tail_sum >= (CntW + 1)'(DEPTH)) ?
                       IdxW'(tail_sum - (CntW + 1)'(DEPTH)) : IdxW'(tail_sum);

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= FullCnt)
    else $error("entry count exceeds depth");

  a_ring_consistent : assert property (@(posedge clk_i) disable iff (!rst_ni)
    tail_q == tail_expect)
    else $error("tail pointer disagrees with head pointer and count");

  a_scan_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> (remain_q < count_q))
    else $error("scan would read past the stored entries");

  a_full_push_drop : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_fire && is_full &&
     ((req_i.req_type == REQ_PUSH_FRONT) || (req_i.req_type == REQ_PUSH_BACK)))
    |=> ($stable(count_q) && $stable(head_q) && $stable(tail_q) && rsp_valid_q &&
         (rsp_q.status == STATUS_FULL)))
    else $error("push on a full queue changed the ring or did not flag full");

  a_one_in_flight : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> !rsp_valid_q)
    else $error("sequencer busy while a response is pending");

endmodule

/* test/dqmm_response_check.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Deque response checker
// Keeps a shadow copy of the ring from every accepted request and compares
// each accepted response, field by field, with the oldest predicted one.
// ----------------------------------------------------------------------------
module dqmm_response_check
  import dqmm_pkg::*;
#(
  parameter int unsigned DEPTH = DefaultDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        req_valid_i,
  input  logic        req_ready_i,
  input  dqmm_req_t   req_i,
  input  logic        rsp_valid_i,
  input  logic        rsp_ready_i,
  input  dqmm_rsp_t   rsp_i,
  output int unsigned mismatch_count_o,
  output int unsigned pending_o,
  output int unsigned full_drops_o,
  output int unsigned empty_hits_o,
  output int unsigned peak_level_o
);

  logic signed [31:0] shadow_ring [DEPTH];
  int unsigned        shadow_front = 0;
  int unsigned        shadow_back  = 0;
  int unsigned        shadow_level = 0;
  dqmm_rsp_t          awaited_rsp_q [$];
  int unsigned        mismatches = 0;
  int unsigned        full_drops = 0;
  int unsigned        empty_hits = 0;
  int unsigned        peak_level = 0;

  function automatic int unsigned ring_step(int unsigned idx, bit forward);
    if (forward) begin
      return (idx + 1 == DEPTH) ? 0 : idx + 1;
    end
    return (idx == 0) ? DEPTH - 1 : idx - 1;
  endfunction

  // Applies one request to the shadow ring and returns the response it owes.
  function automatic dqmm_rsp_t deque_apply(dqmm_req_t r);
    dqmm_rsp_t   rsp;
    int unsigned idx;
    rsp        = '0;
    rsp.status = STATUS_OK;
    case (r.req_type)
      REQ_PUSH_FRONT, REQ_PUSH_BACK: begin
        if (shadow_level == DEPTH) begin
          rsp.status = STATUS_FULL;
          full_drops++;
        end else if (r.req_type == REQ_PUSH_FRONT) begin
          shadow_front = ring_step(shadow_front, 1'b0);
          shadow_ring[shadow_front] = r.push_value;
          shadow_level++;
        end else begin
          shadow_ring[shadow_back] = r.push_value;
          shadow_back = ring_step(shadow_back, 1'b1);
          shadow_level++;
        end
        if (shadow_level > peak_level) peak_level = shadow_level;
      end
      REQ_POP_FRONT, REQ_POP_BACK, REQ_QUERY: begin
        if (shadow_level == 0) begin
          rsp.status = STATUS_EMPTY;
          empty_hits++;
        end else if (r.req_type == REQ_POP_FRONT) begin
          rsp.popped_value = shadow_ring[shadow_front];
          shadow_front = ring_step(shadow_front, 1'b1);
          shadow_level--;
        end else if (r.req_type == REQ_POP_BACK) begin
          shadow_back = ring_step(shadow_back, 1'b0);
          rsp.popped_value = shadow_ring[shadow_back];
          shadow_level--;
        end else begin
          // Walk from front to back, comparing as two's complement.
          idx          = shadow_front;
          rsp.largest  = shadow_ring[idx];
          rsp.smallest = shadow_ring[idx];
          for (int unsigned n = 1; n < shadow_level; n++) begin
            idx = ring_step(idx, 1'b1);
            if ($signed(shadow_ring[idx]) > $signed(rsp.largest)) rsp.largest = shadow_ring[idx];
            if ($signed(shadow_ring[idx]) < $signed(rsp.smallest)) rsp.smallest = shadow_ring[idx];
          end
        end
      end
      default: ;
    endcase
    return rsp;
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    dqmm_rsp_t want;
    if (!rst_ni) begin
      shadow_front = 0;
      shadow_back  = 0;
      shadow_level = 0;
      awaited_rsp_q.delete();
    end else begin
      // A response always belongs to an older request, so it is checked
      // before the request accepted at the same edge is predicted.
      if (rsp_valid_i && rsp_ready_i) begin
        if (awaited_rsp_q.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected response, expected none, actual %h", $time, rsp_i);
        end else begin
          want = awaited_rsp_q.pop_front();
          check_field("status", 32'(want.status), 32'(rsp_i.status));
          check_field("popped_value", want.popped_value, rsp_i.popped_value);
          check_field("largest", want.largest, rsp_i.largest);
          check_field("smallest", want.smallest, rsp_i.smallest);
        end
      end
      if (req_valid_i && req_ready_i) awaited_rsp_q.push_back(deque_apply(req_i));
    end
    mismatch_count_o <= mismatches;
    pending_o        <= awaited_rsp_q.size();
    full_drops_o     <= full_drops;
    empty_hits_o     <= empty_hits;
    peak_level_o     <= peak_level;
  end

endmodule

/* test/deque_with_min_max_scan_top_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Deque with min/max scan testbench
// Drives a directed opening and then phases of random requests that fill the
// ring to full, drain it to empty and mix both, with random gaps on the
// request side and random stalls on the response side. A separate checker
// predicts and compares every response; this module gives the verdict.
// ----------------------------------------------------------------------------
module deque_with_min_max_scan_top_tb;
  import dqmm_pkg::*;

  localparam int unsigned Depth       = DefaultDepth;
  localparam int unsigned RandomItems = 400;
  // The last requests of the run go through with no gaps and no stalls.
  localparam int unsigned QuietTail   = 60;
  // The limit leaves several times what the whole run would cost if every
  // request were a full scan with the worst stalls.
  localparam int unsigned CycleLimit  = 300000;

  // Request codes the block does not define; it must answer them with OK.
  localparam logic [2:0] ReqUnusedFirst = 3'd5;
  localparam logic [2:0] ReqUnusedLast  = 3'd7;

  typedef enum int {
    MODE_FILL,
    MODE_DRAIN,
    MODE_MIXED
  } phase_mode_e;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      req_valid = 1'b0;
  logic      rsp_ready = 1'b0;
  dqmm_req_t req       = '0;
  logic      req_ready;
  logic      rsp_valid;
  dqmm_rsp_t rsp;

  // Gap control: phase_gaps is chosen per phase, quiet_tail turns all idling
  // off for the end of the run.
  logic        phase_gaps = 1'b0;
  logic        quiet_tail = 1'b0;
  int unsigned stall_left = 0;
  int unsigned cycles     = 0;

  // Occupancy as the stimulus sees it; it only steers the phases.
  int unsigned fill_level   = 0;
  int unsigned items_sent   = 0;
  int unsigned random_start = 0;
  int unsigned sent_kind [8];

  int unsigned mismatch_count;
  int unsigned pending;
  int unsigned full_drops;
  int unsigned empty_hits;
  int unsigned peak_level;

  deque_with_min_max_scan_top #(
    .DEPTH(Depth)
  ) uut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .req_valid_i(req_valid),
    .req_ready_o(req_ready),
    .req_i      (req),
    .rsp_valid_o(rsp_valid),
    .rsp_ready_i(rsp_ready),
    .rsp_o      (rsp)
  );

  dqmm_response_check #(
    .DEPTH(Depth)
  ) u_rsp_check (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .req_valid_i     (req_valid),
    .req_ready_i     (req_ready),
    .req_i           (req),
    .rsp_valid_i     (rsp_valid),
    .rsp_ready_i     (rsp_ready),
    .rsp_i           (rsp),
    .mismatch_count_o(mismatch_count),
    .pending_o       (pending),
    .full_drops_o    (full_drops),
    .empty_hits_o    (empty_hits),
    .peak_level_o    (peak_level)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Watchdog: a hung handshake or a lost response ends the run here.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("Timeout after %0d cycles, %0d responses still outstanding", cycles, pending);
      $display("Test completed with failures");
      $finish;
    end
  end

  // Response side: while idling is on, ready drops for a randomly drawn burst;
  // stall_left counts the burst down and ready rises again as it runs out.
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      rsp_ready  <= (stall_left == 1);
    end else if (phase_gaps && !quiet_tail && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(1, 17);
      rsp_ready  <= 1'b0;
    end else begin
      rsp_ready <= 1'b1;
    end
  end

  // Sends one request and returns at the edge that accepts it. Valid is
  // lowered only when a gap comes first; otherwise it stays high straight
  // into the next request, so each step sees a single assignment to it.
  task automatic issue(req_type_e kind, logic signed [31:0] value);
    dqmm_req_t noise;
    dqmm_req_t next_req;
    if (phase_gaps && !quiet_tail && $urandom_range(0, 3) == 0) begin
      // While valid is low the payload carries junk, which must be ignored.
      noise.req_type   = req_type_e'(3'($urandom()));
      noise.push_value = $urandom();
      req_valid <= 1'b0;
      req       <= noise;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    next_req.req_type   = kind;
    next_req.push_value = value;
    req_valid <= 1'b1;
    req       <= next_req;
    do @(posedge clk); while (!req_ready);

    sent_kind[int'(kind)]++;
    items_sent++;
    case (kind)
      REQ_PUSH_FRONT, REQ_PUSH_BACK: if (fill_level < Depth) fill_level++;
      REQ_POP_FRONT, REQ_POP_BACK:   if (fill_level > 0) fill_level--;
      default: ;
    endcase
    if (random_start != 0 && items_sent - random_start + QuietTail == RandomItems) begin
      quiet_tail <= 1'b1;
    end
  endtask

  // Request mix per phase: filling favors pushes, draining favors pops, and
  // every phase keeps a few queries and a little unused-code noise.
  function automatic req_type_e pick_kind(phase_mode_e mode);
    int unsigned roll;
    int unsigned cut_pf, cut_pb, cut_ppf, cut_ppb, cut_q;
    roll = $urandom_range(0, 99);
    case (mode)
      MODE_FILL:  begin cut_pf = 45; cut_pb = 85; cut_ppf = 90; cut_ppb = 93; cut_q = 98; end
      MODE_DRAIN: begin cut_pf = 5;  cut_pb = 10; cut_ppf = 45; cut_ppb = 85; cut_q = 97; end
      default:    begin cut_pf = 22; cut_pb = 44; cut_ppf = 64; cut_ppb = 84; cut_q = 97; end
    endcase
    if (roll < cut_pf)  return REQ_PUSH_FRONT;
    if (roll < cut_pb)  return REQ_PUSH_BACK;
    if (roll < cut_ppf) return REQ_POP_FRONT;
    if (roll < cut_ppb) return REQ_POP_BACK;
    if (roll < cut_q)   return REQ_QUERY;
    return req_type_e'(3'($urandom_range(ReqUnusedFirst, ReqUnusedLast)));
  endfunction

  // Values lean toward the extremes and small magnitudes of both signs, so
  // the scan sees ties and sign-boundary comparisons often.
  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(0, 7))
      0:       return 32'sh7FFF_FFFF;
      1:       return 32'sh8000_0000;
      2:       return 32'($urandom_range(0, 15));
      3:       return 32'($urandom_range(0, 15)) ^ 32'hFFFF_FFFF;
      default: return $urandom();
    endcase
  endfunction

  initial begin
    phase_mode_e mode;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed opening. Everything on an empty queue must report empty.
    issue(REQ_QUERY, $urandom());
    issue(REQ_POP_FRONT, $urandom());
    issue(REQ_POP_BACK, $urandom());
    // Extremes at both ends; front pushes wrap the head below index zero.
    // Front to back the ring then holds 1, 0, max, min, -1.
    issue(REQ_PUSH_FRONT, 32'sh7FFF_FFFF);
    issue(REQ_PUSH_BACK, 32'sh8000_0000);
    issue(REQ_PUSH_FRONT, 32'sd0);
    issue(REQ_PUSH_BACK, 32'shFFFF_FFFF);
    issue(REQ_PUSH_FRONT, 32'sd1);
    issue(REQ_QUERY, $urandom());
    // Unused codes must leave the ring alone and answer OK with zeros.
    for (int c = ReqUnusedFirst; c <= ReqUnusedLast; c++) begin
      issue(req_type_e'(c[2:0]), $urandom());
    end
    issue(REQ_POP_FRONT, $urandom());
    issue(REQ_POP_BACK, $urandom());
    issue(REQ_QUERY, $urandom());
    issue(REQ_POP_BACK, $urandom());
    issue(REQ_POP_FRONT, $urandom());
    // A scan over a single entry reports it as both largest and smallest.
    issue(REQ_QUERY, $urandom());
    issue(REQ_POP_FRONT, $urandom());
    issue(REQ_POP_BACK, $urandom());
    issue(REQ_QUERY, $urandom());

    // Random phases. The first one always fills the ring, so pushes while
    // full and full-length scans show up early.
    random_start = items_sent;
    mode = MODE_FILL;
    while (items_sent - random_start < RandomItems) begin
      phase_gaps <= ($urandom_range(0, 3) != 0);
      case (mode)
        MODE_FILL: begin
          while (fill_level < Depth) issue(pick_kind(MODE_FILL), pick_value());
          repeat ($urandom_range(1, 3)) begin
            issue($urandom_range(0, 1) ? REQ_PUSH_FRONT : REQ_PUSH_BACK, pick_value());
          end
          issue(REQ_QUERY, pick_value());
        end
        MODE_DRAIN: begin
          while (fill_level > 0) issue(pick_kind(MODE_DRAIN), pick_value());
          repeat ($urandom_range(1, 2)) begin
            issue($urandom_range(0, 1) ? REQ_POP_FRONT : REQ_POP_BACK, pick_value());
          end
        end
        default: begin
          repeat ($urandom_range(10, 40)) issue(pick_kind(MODE_MIXED), pick_value());
        end
      endcase
      mode = phase_mode_e'($urandom_range(0, 2));
    end
    req_valid <= 1'b0;

    // One edge first, so the last accepted request is already counted.
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (Depth + 8) @(posedge clk);

    $display("Sent %0d requests: %0d pushes, %0d pops, %0d scans, %0d with unused codes.",
             items_sent, sent_kind[REQ_PUSH_FRONT] + sent_kind[REQ_PUSH_BACK],
             sent_kind[REQ_POP_FRONT] + sent_kind[REQ_POP_BACK], sent_kind[REQ_QUERY],
             items_sent - sent_kind[REQ_PUSH_FRONT] - sent_kind[REQ_PUSH_BACK]
             - sent_kind[REQ_POP_FRONT] - sent_kind[REQ_POP_BACK] - sent_kind[REQ_QUERY]);
    $display("Pushes dropped on a full ring: %0d, empty answers: %0d, deepest fill %0d of %0d.",
             full_drops, empty_hits, peak_level, Depth);
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
